// File: rtl/core/nlms_pkg.sv
package nlms_pkg;

  localparam int MAX_DIRECTIONS = 64;
  localparam int MAX_NEIGHBOURS = 16;
  localparam int DIR_W          = $clog2(MAX_DIRECTIONS);
  localparam int SLOT_W         = $clog2(MAX_NEIGHBOURS);
  localparam int CNT_W          = $clog2(MAX_NEIGHBOURS + 1);
  localparam int NB_AW          = DIR_W + SLOT_W;
  localparam int PRES_W         = 24;
  localparam int DIU_W          = 7;
  localparam int FUNC_W         = 2;
  localparam logic [DIU_W-1:0] DIU_RESET = DIU_W'(50);

  typedef enum logic [FUNC_W-1:0] {
    FN_PRES = 2'd0,
    FN_NB   = 2'd1,
    FN_CNT  = 2'd2,
    FN_SCAN = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIR,
    S_OWN,
    S_NB,
    S_CMP,
    S_REPORT,
    S_NEXT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              we_pres;
    logic              we_nb;
    logic              we_cnt;
    logic [DIR_W-1:0]  dir;
    logic [SLOT_W-1:0] slot;
    logic [DIR_W-1:0]  nidx;
    logic [CNT_W-1:0]  cnt;
    logic [PRES_W-1:0] pval;
  } wr_t;

  typedef struct packed {
    logic [DIR_W-1:0] pres_addr;
    logic [DIR_W-1:0] cnt_addr;
    logic [NB_AW-1:0] nb_addr;
  } rd_req_t;

  typedef struct packed {
    logic [PRES_W-1:0] pres;
    logic [CNT_W-1:0]  cnt;
    logic [DIR_W-1:0]  nb;
  } rd_rsp_t;

endpackage

// File: rtl/core/nlms_store.sv
module nlms_store (
  input  logic             clk,
  input  logic             rst_n,
  input  nlms_pkg::wr_t    wr,
  input  nlms_pkg::rd_req_t req,
  output nlms_pkg::rd_rsp_t rsp
);
  import nlms_pkg::*;

  logic [PRES_W-1:0]         pres_mem [MAX_DIRECTIONS];
  logic [DIR_W-1:0]          nb_mem   [MAX_DIRECTIONS * MAX_NEIGHBOURS];
  logic [CNT_W-1:0]          cnt_mem  [MAX_DIRECTIONS];
  logic [MAX_DIRECTIONS-1:0] cnt_vld_r;

  logic [PRES_W-1:0] pres_rd_r;
  logic [DIR_W-1:0]  nb_rd_r;
  logic [CNT_W-1:0]  cnt_rd_r;
  logic              cnt_vld_rd_r;

  always_ff @(posedge clk) begin
    if (wr.we_pres) begin
      pres_mem[wr.dir] <= wr.pval;
    end
    if (wr.we_nb) begin
      nb_mem[{wr.dir, wr.slot}] <= wr.nidx;
    end
    if (wr.we_cnt) begin
      cnt_mem[wr.dir] <= wr.cnt;
    end
    pres_rd_r <= pres_mem[req.pres_addr];
    nb_rd_r   <= nb_mem[req.nb_addr];
    cnt_rd_r  <= cnt_mem[req.cnt_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r    <= '0;
      cnt_vld_rd_r <= 1'b0;
    end else begin
      if (wr.we_cnt) begin
        cnt_vld_r[wr.dir] <= 1'b1;
      end
      cnt_vld_rd_r <= cnt_vld_r[req.cnt_addr];
    end
  end

  assign rsp.pres = pres_rd_r;
  assign rsp.nb   = nb_rd_r;
  assign rsp.cnt  = cnt_vld_rd_r ? cnt_rd_r : '0;

endmodule

// File: rtl/core/nlms_scan.sv
module nlms_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [nlms_pkg::DIU_W-1:0]   diu,
  output logic                         busy,
  output nlms_pkg::rd_req_t            req,
  input  nlms_pkg::rd_rsp_t            rsp,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nlms_pkg::DIR_W-1:0]   out_peak_direction,
  output logic                         out_found,
  output logic                         out_last
);
  import nlms_pkg::*;

  state_t            state_r, state_nxt;
  logic [DIU_W-1:0]  limit_r, limit_nxt;
  logic [DIR_W-1:0]  d_r, d_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PRES_W-1:0] own_r, own_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [DIR_W-1:0]  pend_dir_r, pend_dir_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIR_W-1:0]  out_dir_r, out_dir_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic [DIU_W-1:0]  limit_sat;
  logic [CNT_W-1:0]  k_inc;
  logic              nb_skip;
  logic [DIR_W-1:0]  pres_addr;

  assign out_free  = !out_valid_r || !out_stall;
  assign limit_sat = (diu > DIU_W'(MAX_DIRECTIONS)) ? DIU_W'(MAX_DIRECTIONS) : diu;
  assign k_inc     = k_r + CNT_W'(1);
  assign nb_skip   = ({1'b0, rsp.nb} >= (DIR_W + 1)'(MAX_DIRECTIONS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r     <= limit_nxt;
    d_r         <= d_nxt;
    k_r         <= k_nxt;
    cnt_r       <= cnt_nxt;
    own_r       <= own_nxt;
    pend_dir_r  <= pend_dir_nxt;
    out_dir_r   <= out_dir_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    d_nxt          = d_r;
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    own_nxt        = own_r;
    pend_valid_nxt = pend_valid_r;
    pend_dir_nxt   = pend_dir_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_dir_nxt    = out_dir_r;
    out_found_nxt  = out_found_r;
    out_last_nxt   = out_last_r;
    pres_addr      = d_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          limit_nxt      = limit_sat;
          d_nxt          = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = (limit_sat == '0) ? S_FINISH : S_DIR;
        end
      end
      S_DIR: begin
        state_nxt = S_OWN;
      end
      S_OWN: begin
        own_nxt = rsp.pres;
        cnt_nxt = rsp.cnt;
        k_nxt   = '0;
        state_nxt = (rsp.cnt == '0) ? S_REPORT : S_NB;
      end
      S_NB: begin
        pres_addr = rsp.nb;
        if (nb_skip) begin
          k_nxt     = k_inc;
          state_nxt = (k_inc == cnt_r) ? S_REPORT : S_NB;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rsp.pres < own_r) begin
          state_nxt = S_NEXT;
        end else begin
          k_nxt     = k_inc;
          state_nxt = (k_inc == cnt_r) ? S_REPORT : S_NB;
        end
      end
      S_REPORT: begin
        if (!pend_valid_r) begin
          pend_valid_nxt = 1'b1;
          pend_dir_nxt   = d_r;
          state_nxt      = S_NEXT;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dir_nxt   = pend_dir_r;
          out_found_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          pend_dir_nxt  = d_r;
          state_nxt     = S_NEXT;
        end
      end
      S_NEXT: begin
        if (({1'b0, d_r} + DIU_W'(1)) == limit_r) begin
          state_nxt = S_FINISH;
        end else begin
          d_nxt     = d_r + DIR_W'(1);
          state_nxt = S_DIR;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_dir_nxt    = pend_valid_r ? pend_dir_r : '0;
          out_found_nxt  = pend_valid_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign req.pres_addr = pres_addr;
  assign req.cnt_addr  = d_r;
  assign req.nb_addr   = {d_r, k_nxt[SLOT_W-1:0]};

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_peak_direction = out_dir_r;
  assign out_found          = out_found_r;
  assign out_last           = out_last_r;

endmodule

// File: rtl/core/neighbour_local_minimum_scan.sv
// Load items are written to the stores at the edge that accepts them. Scan item: per
// direction, count and pressure reads, then slot and pressure reads per neighbour until
// one is lower, a report for a minimum, any output stall; the input stalls meanwhile.
// A minimum waits for the next one or the scan end before it enters the output register.
// Reset: control clears, neighbour counts read as zero, directions_in_use is 50;
// pressure and neighbour stores hold no defined value until written.
module neighbour_local_minimum_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [nlms_pkg::FUNC_W-1:0]   in_func,
  input  logic [nlms_pkg::DIR_W-1:0]    in_direction,
  input  logic [nlms_pkg::SLOT_W-1:0]   in_slot,
  input  logic [nlms_pkg::DIR_W-1:0]    in_neighbour_index,
  input  logic [nlms_pkg::CNT_W-1:0]    in_neighbour_total,
  input  logic [nlms_pkg::PRES_W-1:0]   in_pressure_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nlms_pkg::DIR_W-1:0]    out_peak_direction,
  output logic                          out_found,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [nlms_pkg::DIU_W-1:0]    cfg_wdata
);
  import nlms_pkg::*;

  logic [DIU_W-1:0] diu_r;
  logic             busy;
  logic             in_accept;
  logic             dir_ok;
  func_t            fn;
  wr_t              wr;
  rd_req_t          req;
  rd_rsp_t          rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diu_r <= DIU_RESET;
    end else if (cfg_we) begin
      diu_r <= cfg_wdata;
    end
  end

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign fn        = func_t'(in_func);
  assign dir_ok    = ({1'b0, in_direction} < (DIR_W + 1)'(MAX_DIRECTIONS));

  assign wr.we_pres = in_accept && (fn == FN_PRES) && dir_ok;
  assign wr.we_nb   = in_accept && (fn == FN_NB) && dir_ok;
  assign wr.we_cnt  = in_accept && (fn == FN_CNT) && dir_ok;
  assign wr.dir     = in_direction;
  assign wr.slot    = in_slot;
  assign wr.nidx    = in_neighbour_index;
  assign wr.cnt     = (in_neighbour_total > CNT_W'(MAX_NEIGHBOURS)) ?
                      CNT_W'(MAX_NEIGHBOURS) : in_neighbour_total;
  assign wr.pval    = in_pressure_value;

  nlms_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .req   (req),
    .rsp   (rsp)
  );

  nlms_scan u_scan (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (in_accept && (fn == FN_SCAN)),
    .diu                (diu_r),
    .busy               (busy),
    .req                (req),
    .rsp                (rsp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_peak_direction (out_peak_direction),
    .out_found          (out_found),
    .out_last           (out_last)
  );

  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FN_SCAN) |=> in_stall)
    else $error("scan accepted without going busy");

  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last)
    else $error("not-found result without last");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_peak_direction == '0))
    else $error("not-found result with nonzero direction");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(wr.we_pres || wr.we_nb || wr.we_cnt))
    else $error("store write during scan");

endmodule
